FILE: design/spm_pkg.sv
// stationary pose health monitor: shared types, constants and the arc tangent table
// no dependencies
`timescale 1ns / 1ps

package spm_pkg;

    localparam int POS_W      = 32;
    localparam int Q_W        = 16;
    localparam int CNT_W      = 20;
    localparam int STAT_W     = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int QUEUE_DEPTH = 2;

    localparam int ISQ_RAD_W  = 68;
    localparam int ISQ_ROOT_W = 34;
    localparam int DIV_DVD_W  = 54;
    localparam int DIV_DSR_W  = 32;
    localparam int CORD_STEPS = 24;
    localparam int CORD_Z_W   = 27;
    localparam int CORD_IN_W  = 32;

    localparam logic [CNT_W-1:0]  CNT_MAX  = '1;
    localparam logic [STAT_W-1:0] STAT_MAX = '1;
    localparam logic [19:0]       US_PER_S = 20'd1000000;
    localparam logic [28:0]       ONE_Q28  = 29'h1000_0000;

    localparam logic [19:0] RST_MIN_COUNT  = 20'd10;
    localparam logic [19:0] RST_MIN_GAP    = 20'd100;
    localparam logic [31:0] RST_POS_LIMIT  = 32'd655;
    localparam logic [31:0] RST_ANG_LIMIT  = 32'd655;
    localparam logic [31:0] RST_SPD_LIMIT  = 32'd6554;
    localparam logic [31:0] RST_RATE_LIMIT = 32'd6554;
    localparam logic [31:0] RST_ACC_LIMIT  = 32'd65536;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_COUNT  = 3'd0,
        CFG_MIN_GAP    = 3'd1,
        CFG_POS_LIMIT  = 3'd2,
        CFG_ANG_LIMIT  = 3'd3,
        CFG_SPD_LIMIT  = 3'd4,
        CFG_RATE_LIMIT = 3'd5,
        CFG_ACC_LIMIT  = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic [31:0]        time_us;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [15:0] quat_w;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic               final_sample;
    } in_word_t;

    typedef struct packed {
        logic [19:0] sample_count;
        logic [31:0] pos_drift;
        logic [31:0] ang_drift;
        logic [31:0] peak_speed;
        logic [31:0] peak_ang_rate;
        logic [31:0] peak_acc;
        logic        healthy;
    } out_word_t;

    typedef struct packed {
        logic [19:0] min_sample_count;
        logic [19:0] min_gap_us;
        logic [31:0] drift_pos_limit;
        logic [31:0] drift_ang_limit;
        logic [31:0] speed_limit;
        logic [31:0] ang_rate_limit;
        logic [31:0] acc_limit;
    } cfg_t;

    typedef enum logic [3:0] {
        S_IDLE, S_DSQ, S_DACC, S_QMUL, S_QACC, S_QCLAMP, S_QSQR, S_QRAD,
        S_SQRT, S_CORDIC, S_RMUL, S_DIV, S_APPLY, S_FIN, S_EMIT
    } state_t;

    typedef enum logic [2:0] {
        J_SPEED, J_ANGRATE, J_ACC, J_PDRIFT, J_ADRIFT
    } job_t;

    // arc tangent of 2^-i in units of 2^-24 rad
    function automatic logic signed [CORD_Z_W-1:0] cord_atan(input logic [4:0] i);
        case (i)
            5'd0:  return 27'sd13176795;
            5'd1:  return 27'sd7778716;
            5'd2:  return 27'sd4110060;
            5'd3:  return 27'sd2086331;
            5'd4:  return 27'sd1047214;
            5'd5:  return 27'sd524117;
            5'd6:  return 27'sd262123;
            5'd7:  return 27'sd131069;
            5'd8:  return 27'sd65536;
            5'd9:  return 27'sd32768;
            5'd10: return 27'sd16384;
            5'd11: return 27'sd8192;
            5'd12: return 27'sd4096;
            5'd13: return 27'sd2048;
            5'd14: return 27'sd1024;
            5'd15: return 27'sd512;
            5'd16: return 27'sd256;
            5'd17: return 27'sd128;
            5'd18: return 27'sd64;
            5'd19: return 27'sd32;
            5'd20: return 27'sd16;
            5'd21: return 27'sd8;
            5'd22: return 27'sd4;
            5'd23: return 27'sd2;
            default: return 27'sd0;
        endcase
    endfunction

endpackage

FILE: design/spm_front.sv
// front end: takes input words and holds them in a short queue for the back end
// depends on spm_pkg
`timescale 1ns / 1ps

module spm_front #(
    parameter int DEPTH = spm_pkg::QUEUE_DEPTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  spm_pkg::in_word_t s_word,
    output logic              q_valid,
    input  logic              q_ready,
    output spm_pkg::in_word_t q_word
);
    import spm_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int FILL_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(DEPTH);

    in_word_t          mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic              push, pop;

    assign s_ready = (fill_reg != FULL_FILL);
    assign q_valid = (fill_reg != '0);
    assign q_word  = mem_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= s_word;
        end
    end

endmodule

FILE: design/spm_isqrt.sv
// bit-serial integer square root, two radicand bits per cycle
// depends on spm_pkg
`timescale 1ns / 1ps

module spm_isqrt (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [spm_pkg::ISQ_RAD_W-1:0]  radicand,
    output logic [spm_pkg::ISQ_ROOT_W-1:0] root,
    output logic                           done
);
    import spm_pkg::*;

    localparam int REM_W = ISQ_ROOT_W + 3;

    logic [ISQ_RAD_W-1:0]  rad_reg, rad_next;
    logic [REM_W-1:0]      rem_reg, rem_next;
    logic [ISQ_ROOT_W-1:0] root_reg, root_next;
    logic [5:0]            cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [REM_W-1:0]      rem_sh, trial;
    logic                  fits;

    assign rem_sh = {rem_reg[REM_W-3:0], rad_reg[ISQ_RAD_W-1 -: 2]};
    assign trial  = {1'b0, root_reg, 2'b01};
    assign fits   = (rem_sh >= trial);
    assign root   = root_reg;
    assign done   = done_reg;

    always_comb begin
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = 6'(ISQ_ROOT_W - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rad_next  = {rad_reg[ISQ_RAD_W-3:0], 2'b00};
            rem_next  = fits ? (rem_sh - trial) : rem_sh;
            root_next = {root_reg[ISQ_ROOT_W-2:0], fits};
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        cnt_reg  <= cnt_next;
    end

endmodule

FILE: design/spm_div.sv
// restoring divider, one quotient bit per cycle
// depends on spm_pkg
`timescale 1ns / 1ps

module spm_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [spm_pkg::DIV_DVD_W-1:0] dividend,
    input  logic [spm_pkg::DIV_DSR_W-1:0] divisor,
    output logic [spm_pkg::DIV_DVD_W-1:0] quotient,
    output logic                          done
);
    import spm_pkg::*;

    logic [DIV_DVD_W-1:0] dvd_reg, dvd_next;
    logic [DIV_DSR_W-1:0] dsr_reg, dsr_next;
    logic [DIV_DSR_W-1:0] rem_reg, rem_next;
    logic [5:0]           cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_DSR_W:0]   rem_sh, diff;
    logic                 fits;

    assign rem_sh   = {rem_reg, dvd_reg[DIV_DVD_W-1]};
    assign diff     = rem_sh - {1'b0, dsr_reg};
    assign fits     = (rem_sh >= {1'b0, dsr_reg});
    assign quotient = dvd_reg;
    assign done     = done_reg;

    always_comb begin
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            dvd_next  = dividend;
            dsr_next  = divisor;
            rem_next  = '0;
            cnt_next  = 6'(DIV_DVD_W - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            dvd_next = {dvd_reg[DIV_DVD_W-2:0], fits};
            rem_next = fits ? diff[DIV_DSR_W-1:0] : rem_sh[DIV_DSR_W-1:0];
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
        cnt_reg <= cnt_next;
    end

endmodule

FILE: design/spm_cordic.sv
// vectoring cordic: angle of (x, y), returned as twice the angle in Q16.16
// depends on spm_pkg
`timescale 1ns / 1ps

module spm_cordic (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [spm_pkg::CORD_IN_W-1:0] x_in,
    input  logic [spm_pkg::CORD_IN_W-1:0] y_in,
    output logic [spm_pkg::STAT_W-1:0]    angle,
    output logic                          done
);
    import spm_pkg::*;

    logic signed [CORD_IN_W-1:0] x_reg, x_next;
    logic signed [CORD_IN_W-1:0] y_reg, y_next;
    logic signed [CORD_Z_W-1:0]  z_reg, z_next;
    logic [4:0]                  i_reg, i_next;
    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic signed [CORD_IN_W-1:0] dx, dy;
    logic [CORD_Z_W-1:0]         z_pos;
    logic [CORD_Z_W:0]           z_rnd;

    assign dx    = y_reg >>> i_reg;
    assign dy    = x_reg >>> i_reg;
    assign z_pos = z_reg[CORD_Z_W-1] ? '0 : z_reg;
    assign z_rnd = {1'b0, z_pos} + (CORD_Z_W + 1)'(64);
    assign angle = STAT_W'(z_rnd[CORD_Z_W:7]);
    assign done  = done_reg;

    always_comb begin
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        i_next    = i_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            x_next    = x_in;
            y_next    = y_in;
            z_next    = '0;
            i_next    = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (i_reg == 5'(CORD_STEPS) || y_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                if (y_reg > 0) begin
                    x_next = x_reg + dx;
                    y_next = y_reg - dy;
                    z_next = z_reg + cord_atan(i_reg);
                end else begin
                    x_next = x_reg - dx;
                    y_next = y_reg + dy;
                    z_next = z_reg - cord_atan(i_reg);
                end
                i_next = i_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
        i_reg <= i_next;
    end

endmodule

FILE: design/spm_core.sv
// back end: sequencer over shared square root, divider and cordic; window state,
// running peaks and the result register. depends on spm_pkg, spm_isqrt, spm_div, spm_cordic
`timescale 1ns / 1ps

module spm_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  spm_pkg::cfg_t      cfg,
    input  logic               q_valid,
    output logic               q_ready,
    input  spm_pkg::in_word_t  q_word,
    output logic               m_valid,
    input  logic               m_ready,
    output spm_pkg::out_word_t m_word
);
    import spm_pkg::*;

    localparam int PK_POS = 0;
    localparam int PK_ANG = 1;
    localparam int PK_SPD = 2;
    localparam int PK_RATE = 3;
    localparam int PK_ACC = 4;
    localparam logic [ISQ_RAD_W-1:0] ONE_SQ_Q56 = ISQ_RAD_W'(1) << 56;

    state_t             state_reg, state_next;
    job_t               job_reg, job_next;
    in_word_t           cur_reg, cur_next;
    logic               have_first_reg, have_first_next;
    logic signed [31:0] first_pos_reg [3], first_pos_next [3];
    logic signed [31:0] last_pos_reg [3], last_pos_next [3];
    logic signed [15:0] first_q_reg [4], first_q_next [4];
    logic signed [15:0] last_q_reg [4], last_q_next [4];
    logic [31:0]        last_time_reg, last_time_next;
    logic [31:0]        last_speed_reg, last_speed_next;
    logic               last_speed_valid_reg, last_speed_valid_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [STAT_W-1:0]  peak_reg [5], peak_next [5];
    logic [31:0]        dt_reg, dt_next;
    logic [1:0]         k_reg, k_next;
    logic [65:0]        dprod_reg, dprod_next;
    logic [67:0]        acc_reg, acc_next;
    logic signed [31:0] qprod_reg, qprod_next;
    logic signed [33:0] dot_reg, dot_next;
    logic [28:0]        c_reg, c_next;
    logic [57:0]        cprod_reg, cprod_next;
    logic [67:0]        rad_reg, rad_next;
    logic               isq_start_reg, isq_start_next;
    logic               div_start_reg, div_start_next;
    logic               cord_start_reg, cord_start_next;
    logic [33:0]        num_reg, num_next;
    logic [53:0]        mprod_reg, mprod_next;
    logic [31:0]        rate_reg, rate_next;
    logic [31:0]        sp_reg, sp_next;
    logic               out_valid_reg, out_valid_next;
    out_word_t          out_reg, out_next;

    logic signed [31:0] cur_pos [3], ref_pos [3];
    logic signed [15:0] cur_q [4], ref_q [4];
    logic signed [32:0] pdiff;
    logic [32:0]        pabs;
    logic [33:0]        dot_abs;
    logic [67:0]        acc_sum;
    logic [32:0]        dt_full;
    logic               pair_ok;
    logic               angle_job;
    logic               emit_ok;
    logic [ISQ_ROOT_W-1:0] isq_root;
    logic               isq_done;
    logic [DIV_DVD_W-1:0] quot;
    logic               div_done;
    logic [STAT_W-1:0]  cord_angle;
    logic               cord_done;
    logic [31:0]        root_sat;
    logic [31:0]        sp_diff;

    spm_isqrt u_isqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (isq_start_reg),
        .radicand (rad_reg),
        .root     (isq_root),
        .done     (isq_done)
    );

    spm_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start_reg),
        .dividend (mprod_reg),
        .divisor  (dt_reg),
        .quotient (quot),
        .done     (div_done)
    );

    spm_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cord_start_reg),
        .x_in    (CORD_IN_W'(c_reg)),
        .y_in    (CORD_IN_W'(isq_root)),
        .angle   (cord_angle),
        .done    (cord_done)
    );

    always_comb begin
        cur_pos[0] = cur_reg.pos_x;
        cur_pos[1] = cur_reg.pos_y;
        cur_pos[2] = cur_reg.pos_z;
        cur_q[0]   = cur_reg.quat_w;
        cur_q[1]   = cur_reg.quat_x;
        cur_q[2]   = cur_reg.quat_y;
        cur_q[3]   = cur_reg.quat_z;
        for (int i = 0; i < 3; i++) begin
            ref_pos[i] = (job_reg == J_SPEED) ? last_pos_reg[i] : first_pos_reg[i];
        end
        for (int i = 0; i < 4; i++) begin
            ref_q[i] = (job_reg == J_ANGRATE) ? last_q_reg[i] : first_q_reg[i];
        end
    end

    assign pdiff     = {cur_pos[k_reg][31], cur_pos[k_reg]} - {ref_pos[k_reg][31], ref_pos[k_reg]};
    assign pabs      = pdiff[32] ? 33'(-pdiff) : 33'(pdiff);
    assign dot_abs   = dot_reg[33] ? 34'(-dot_reg) : 34'(dot_reg);
    assign acc_sum   = acc_reg + 68'(dprod_reg);
    assign dt_full   = {1'b0, q_word.time_us} - {1'b0, last_time_reg};
    assign pair_ok   = have_first_reg && !dt_full[32] && (dt_full[31:0] >= 32'(cfg.min_gap_us));
    assign angle_job = (job_reg == J_ANGRATE) || (job_reg == J_ADRIFT);
    assign emit_ok   = !out_valid_reg || m_ready;
    assign root_sat  = (isq_root[ISQ_ROOT_W-1:32] != '0) ? STAT_MAX : isq_root[31:0];
    assign sp_diff   = (sp_reg > last_speed_reg) ? (sp_reg - last_speed_reg)
                                                 : (last_speed_reg - sp_reg);

    assign q_ready = (state_reg == S_IDLE);
    assign m_valid = out_valid_reg;
    assign m_word  = out_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (q_valid) state_next = S_DSQ;
            end
            S_DSQ:  state_next = S_DACC;
            S_DACC: begin
                state_next = (k_reg == 2'd2) ? S_SQRT : S_DSQ;
            end
            S_QMUL: state_next = S_QACC;
            S_QACC: begin
                state_next = (k_reg == 2'd3) ? S_QCLAMP : S_QMUL;
            end
            S_QCLAMP: state_next = S_QSQR;
            S_QSQR:   state_next = S_QRAD;
            S_QRAD:   state_next = S_SQRT;
            S_SQRT: begin
                if (isq_done) begin
                    if (angle_job) state_next = S_CORDIC;
                    else if (job_reg == J_SPEED) state_next = S_RMUL;
                    else state_next = S_QMUL;
                end
            end
            S_CORDIC: begin
                if (cord_done) state_next = (job_reg == J_ANGRATE) ? S_RMUL : S_FIN;
            end
            S_RMUL: state_next = (dt_reg == '0) ? S_APPLY : S_DIV;
            S_DIV: begin
                if (div_done) state_next = S_APPLY;
            end
            S_APPLY: begin
                case (job_reg)
                    J_SPEED:   state_next = S_QMUL;
                    J_ANGRATE: state_next = last_speed_valid_reg ? S_RMUL : S_DSQ;
                    default:   state_next = S_DSQ;
                endcase
            end
            S_FIN: state_next = cur_reg.final_sample ? S_EMIT : S_IDLE;
            S_EMIT: begin
                if (emit_ok) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        job_next              = job_reg;
        cur_next              = cur_reg;
        have_first_next       = have_first_reg;
        first_pos_next        = first_pos_reg;
        last_pos_next         = last_pos_reg;
        first_q_next          = first_q_reg;
        last_q_next           = last_q_reg;
        last_time_next        = last_time_reg;
        last_speed_next       = last_speed_reg;
        last_speed_valid_next = last_speed_valid_reg;
        count_next            = count_reg;
        peak_next             = peak_reg;
        dt_next               = dt_reg;
        k_next                = k_reg;
        dprod_next            = dprod_reg;
        acc_next              = acc_reg;
        qprod_next            = qprod_reg;
        dot_next              = dot_reg;
        c_next                = c_reg;
        cprod_next            = cprod_reg;
        rad_next              = rad_reg;
        isq_start_next        = 1'b0;
        div_start_next        = 1'b0;
        cord_start_next       = 1'b0;
        num_next              = num_reg;
        mprod_next            = mprod_reg;
        rate_next             = rate_reg;
        sp_next               = sp_reg;
        out_valid_next        = out_valid_reg && !m_ready;
        out_next              = out_reg;

        case (state_reg)
            S_IDLE: begin
                if (q_valid) begin
                    cur_next   = q_word;
                    count_next = (count_reg == CNT_MAX) ? count_reg : count_reg + 1'b1;
                    if (!have_first_reg) begin
                        have_first_next   = 1'b1;
                        first_pos_next[0] = q_word.pos_x;
                        first_pos_next[1] = q_word.pos_y;
                        first_pos_next[2] = q_word.pos_z;
                        first_q_next[0]   = q_word.quat_w;
                        first_q_next[1]   = q_word.quat_x;
                        first_q_next[2]   = q_word.quat_y;
                        first_q_next[3]   = q_word.quat_z;
                    end
                    dt_next  = dt_full[31:0];
                    job_next = pair_ok ? J_SPEED : J_PDRIFT;
                    k_next   = '0;
                    acc_next = '0;
                end
            end
            S_DSQ: begin
                dprod_next = pabs * pabs;
            end
            S_DACC: begin
                acc_next = acc_sum;
                if (k_reg == 2'd2) begin
                    rad_next       = acc_sum;
                    isq_start_next = 1'b1;
                end else begin
                    k_next = k_reg + 1'b1;
                end
            end
            S_QMUL: begin
                qprod_next = ref_q[k_reg] * cur_q[k_reg];
            end
            S_QACC: begin
                dot_next = dot_reg + 34'(qprod_reg);
                if (k_reg != 2'd3) k_next = k_reg + 1'b1;
            end
            S_QCLAMP: begin
                c_next = (dot_abs > 34'(ONE_Q28)) ? ONE_Q28 : dot_abs[28:0];
            end
            S_QSQR: begin
                cprod_next = c_reg * c_reg;
            end
            S_QRAD: begin
                rad_next       = ONE_SQ_Q56 - 68'(cprod_reg);
                isq_start_next = 1'b1;
            end
            S_SQRT: begin
                if (isq_done) begin
                    if (angle_job) begin
                        cord_start_next = 1'b1;
                    end else if (job_reg == J_SPEED) begin
                        num_next = isq_root;
                    end else begin
                        if (root_sat > peak_reg[PK_POS]) peak_next[PK_POS] = root_sat;
                        job_next = J_ADRIFT;
                        k_next   = '0;
                        dot_next = '0;
                    end
                end
            end
            S_CORDIC: begin
                if (cord_done) begin
                    if (job_reg == J_ANGRATE) begin
                        num_next = 34'(cord_angle);
                    end else if (cord_angle > peak_reg[PK_ANG]) begin
                        peak_next[PK_ANG] = cord_angle;
                    end
                end
            end
            S_RMUL: begin
                if (dt_reg == '0) begin
                    rate_next = (num_reg != '0) ? STAT_MAX : '0;
                end else begin
                    mprod_next     = num_reg * US_PER_S;
                    div_start_next = 1'b1;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    rate_next = (quot[DIV_DVD_W-1:32] != '0) ? STAT_MAX : quot[31:0];
                end
            end
            S_APPLY: begin
                case (job_reg)
                    J_SPEED: begin
                        if (rate_reg > peak_reg[PK_SPD]) peak_next[PK_SPD] = rate_reg;
                        sp_next  = rate_reg;
                        job_next = J_ANGRATE;
                        k_next   = '0;
                        dot_next = '0;
                    end
                    J_ANGRATE: begin
                        if (rate_reg > peak_reg[PK_RATE]) peak_next[PK_RATE] = rate_reg;
                        if (last_speed_valid_reg) begin
                            num_next = 34'(sp_diff);
                            job_next = J_ACC;
                        end else begin
                            last_speed_next       = sp_reg;
                            last_speed_valid_next = 1'b1;
                            job_next              = J_PDRIFT;
                            k_next                = '0;
                            acc_next              = '0;
                        end
                    end
                    default: begin
                        if (rate_reg > peak_reg[PK_ACC]) peak_next[PK_ACC] = rate_reg;
                        last_speed_next       = sp_reg;
                        last_speed_valid_next = 1'b1;
                        job_next              = J_PDRIFT;
                        k_next                = '0;
                        acc_next              = '0;
                    end
                endcase
            end
            S_FIN: begin
                last_pos_next  = cur_pos;
                last_q_next    = cur_q;
                last_time_next = cur_reg.time_us;
            end
            S_EMIT: begin
                if (emit_ok) begin
                    out_valid_next        = 1'b1;
                    out_next.sample_count = count_reg;
                    if (count_reg < cfg.min_sample_count) begin
                        out_next.pos_drift     = '0;
                        out_next.ang_drift     = '0;
                        out_next.peak_speed    = '0;
                        out_next.peak_ang_rate = '0;
                        out_next.peak_acc      = '0;
                        out_next.healthy       = 1'b0;
                    end else begin
                        out_next.pos_drift     = peak_reg[PK_POS];
                        out_next.ang_drift     = peak_reg[PK_ANG];
                        out_next.peak_speed    = peak_reg[PK_SPD];
                        out_next.peak_ang_rate = peak_reg[PK_RATE];
                        out_next.peak_acc      = peak_reg[PK_ACC];
                        out_next.healthy = (peak_reg[PK_POS] <= cfg.drift_pos_limit)
                                        && (peak_reg[PK_ANG] <= cfg.drift_ang_limit)
                                        && (peak_reg[PK_SPD] <= cfg.speed_limit)
                                        && (peak_reg[PK_RATE] <= cfg.ang_rate_limit)
                                        && (peak_reg[PK_ACC] <= cfg.acc_limit);
                    end
                    // window clear
                    have_first_next       = 1'b0;
                    last_time_next        = '0;
                    last_speed_next       = '0;
                    last_speed_valid_next = 1'b0;
                    count_next            = '0;
                    for (int i = 0; i < 3; i++) begin
                        first_pos_next[i] = '0;
                        last_pos_next[i]  = '0;
                    end
                    for (int i = 0; i < 4; i++) begin
                        first_q_next[i] = '0;
                        last_q_next[i]  = '0;
                    end
                    for (int i = 0; i < 5; i++) begin
                        peak_next[i] = '0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg            <= S_IDLE;
            job_reg              <= J_PDRIFT;
            have_first_reg       <= 1'b0;
            last_time_reg        <= '0;
            last_speed_reg       <= '0;
            last_speed_valid_reg <= 1'b0;
            count_reg            <= '0;
            isq_start_reg        <= 1'b0;
            div_start_reg        <= 1'b0;
            cord_start_reg       <= 1'b0;
            out_valid_reg        <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                first_pos_reg[i] <= '0;
                last_pos_reg[i]  <= '0;
            end
            for (int i = 0; i < 4; i++) begin
                first_q_reg[i] <= '0;
                last_q_reg[i]  <= '0;
            end
            for (int i = 0; i < 5; i++) begin
                peak_reg[i] <= '0;
            end
        end else begin
            state_reg            <= state_next;
            job_reg              <= job_next;
            have_first_reg       <= have_first_next;
            last_time_reg        <= last_time_next;
            last_speed_reg       <= last_speed_next;
            last_speed_valid_reg <= last_speed_valid_next;
            count_reg            <= count_next;
            isq_start_reg        <= isq_start_next;
            div_start_reg        <= div_start_next;
            cord_start_reg       <= cord_start_next;
            out_valid_reg        <= out_valid_next;
            first_pos_reg        <= first_pos_next;
            last_pos_reg         <= last_pos_next;
            first_q_reg          <= first_q_next;
            last_q_reg           <= last_q_next;
            peak_reg             <= peak_next;
        end
        cur_reg   <= cur_next;
        dt_reg    <= dt_next;
        k_reg     <= k_next;
        dprod_reg <= dprod_next;
        acc_reg   <= acc_next;
        qprod_reg <= qprod_next;
        dot_reg   <= dot_next;
        c_reg     <= c_next;
        cprod_reg <= cprod_next;
        rad_reg   <= rad_next;
        num_reg   <= num_next;
        mprod_reg <= mprod_next;
        rate_reg  <= rate_next;
        sp_reg    <= sp_next;
        out_reg   <= out_next;
    end

endmodule

FILE: design/stationary_pose_health_monitor.sv
// stationary pose health monitor top level: configuration registers, front queue, back end
// depends on spm_pkg, spm_front, spm_core
//
//   port group   direction   handshake            payload
//   s_*          in          s_valid / s_ready    s_word  (in_word_t)
//   m_*          out         m_valid / m_ready    m_word  (out_word_t)
//   cfg_*        in          cfg_wr_en            cfg_index, cfg_wdata
//
// a word is quickest when it is the first of a window or a short step and slowest when
// it is a usable step (speed, angular rate and acceleration); its time is set by the shared
// 34-step square root, 54-step divider and up to 24-step cordic run one after another.
// reset is synchronous and active low; it restores register defaults and clears the window.
// until full, the front queue takes words as the back end works or a result awaits m_ready.
`timescale 1ns / 1ps

module stationary_pose_health_monitor #(
    parameter int QUEUE_DEPTH = spm_pkg::QUEUE_DEPTH
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  spm_pkg::in_word_t               s_word,
    output logic                            m_valid,
    input  logic                            m_ready,
    output spm_pkg::out_word_t              m_word,
    input  logic                            cfg_wr_en,
    input  logic [spm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [spm_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import spm_pkg::*;

    cfg_t     cfg_reg, cfg_next;
    logic     q_valid, q_ready;
    in_word_t q_word;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_idx_t'(cfg_index))
                CFG_MIN_COUNT:  cfg_next.min_sample_count = cfg_wdata[19:0];
                CFG_MIN_GAP:    cfg_next.min_gap_us       = cfg_wdata[19:0];
                CFG_POS_LIMIT:  cfg_next.drift_pos_limit  = cfg_wdata;
                CFG_ANG_LIMIT:  cfg_next.drift_ang_limit  = cfg_wdata;
                CFG_SPD_LIMIT:  cfg_next.speed_limit      = cfg_wdata;
                CFG_RATE_LIMIT: cfg_next.ang_rate_limit   = cfg_wdata;
                CFG_ACC_LIMIT:  cfg_next.acc_limit        = cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_sample_count <= RST_MIN_COUNT;
            cfg_reg.min_gap_us       <= RST_MIN_GAP;
            cfg_reg.drift_pos_limit  <= RST_POS_LIMIT;
            cfg_reg.drift_ang_limit  <= RST_ANG_LIMIT;
            cfg_reg.speed_limit      <= RST_SPD_LIMIT;
            cfg_reg.ang_rate_limit   <= RST_RATE_LIMIT;
            cfg_reg.acc_limit        <= RST_ACC_LIMIT;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    spm_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_word  (s_word),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_word  (q_word)
    );

    spm_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_word  (q_word),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_word  (m_word)
    );

    a_no_result_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result word right after reset");

    a_healthy_needs_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_word.healthy) |-> (m_word.sample_count >= cfg_reg.min_sample_count))
        else $error("healthy with too few samples");

    a_short_window_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_word.sample_count < cfg_reg.min_sample_count))
        |-> (m_word.pos_drift == '0 && m_word.peak_speed == '0 && !m_word.healthy))
        else $error("short window reports statistics");

    a_healthy_within_limits: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_word.healthy)
        |-> (m_word.pos_drift <= cfg_reg.drift_pos_limit
             && m_word.peak_acc <= cfg_reg.acc_limit))
        else $error("healthy with a statistic over its limit");

endmodule
